### hdl/lant_pkg.sv
// ----------------------------------------------------------------------------
// lant_pkg
// Shared constants and codes for the Langton's ant grid stepper.
// ----------------------------------------------------------------------------
package lant_pkg;

	// default grid side (cells per row and rows per grid)
	localparam int LANT_GRID_SIDE_DEF = 512;

	// width of the position fields on the ports
	localparam int FIELD_W = 9;

	// width of the configuration write data (widest register)
	localparam int CFG_W = 16;

	// item function codes
	localparam logic [1:0] FUNC_RUN     = 2'd0;
	localparam logic [1:0] FUNC_PAINT_B = 2'd1;
	localparam logic [1:0] FUNC_PAINT_W = 2'd2;
	localparam logic [1:0] FUNC_READ    = 2'd3;

	// configuration register indexes
	localparam logic REG_STEPS = 1'b0;
	localparam logic REG_REACH = 1'b1;

	// configuration reset values
	localparam logic [15:0] STEPS_RST = 16'd100;
	localparam logic [8:0]  REACH_RST = 9'd10;

	// headings
	localparam logic [1:0] HEAD_N = 2'd0;
	localparam logic [1:0] HEAD_E = 2'd1;
	localparam logic [1:0] HEAD_S = 2'd2;
	localparam logic [1:0] HEAD_W = 2'd3;

	// heading increments for a right and a left turn
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT  = 2'd3;

endpackage

### hdl/lant_grid_mem.sv
// ----------------------------------------------------------------------------
// lant_grid_mem
// Cell grid storage: one row of cells per word, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module lant_grid_mem import lant_pkg::*; #(
	parameter int GRID_SIDE = LANT_GRID_SIDE_DEF,
	localparam int CW = $clog2(GRID_SIDE)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [CW-1:0]        rd_addr,
	output logic [GRID_SIDE-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [CW-1:0]        wr_addr,
	input  logic [GRID_SIDE-1:0] wr_data
);

	logic [GRID_SIDE-1:0] mem [GRID_SIDE];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/lant_ant.sv
// ----------------------------------------------------------------------------
// lant_ant
// Ant position, heading and step counter; one step per strobe, turning on the
// cell color and wrapping around the torus.
// ----------------------------------------------------------------------------
module lant_ant import lant_pkg::*; #(
	parameter int GRID_SIDE = LANT_GRID_SIDE_DEF,
	localparam int CW = $clog2(GRID_SIDE)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  logic          step_cell,
	output logic [CW-1:0] col,
	output logic [CW-1:0] row,
	output logic [1:0]    head,
	output logic [31:0]   count
);

	localparam logic [CW-1:0] CENTRE = CW'(GRID_SIDE / 2);
	localparam logic [CW-1:0] LAST   = CW'(GRID_SIDE - 1);

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [1:0]    head_q;
	logic [31:0]   count_q;
	logic [1:0]    new_head;

	// right on white, left on black
	assign new_head = head_q + (step_cell ? TURN_LEFT : TURN_RIGHT);

	// turn, move with wrap, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= CENTRE;
			row_q   <= CENTRE;
			head_q  <= HEAD_N;
			count_q <= 32'd0;
		end else if (step_en) begin
			head_q  <= new_head;
			count_q <= count_q + 32'd1;
			case (new_head)
				HEAD_N: row_q <= (row_q == '0) ? LAST : row_q - CW'(1);
				HEAD_E: col_q <= (col_q == LAST) ? '0 : col_q + CW'(1);
				HEAD_S: row_q <= (row_q == LAST) ? '0 : row_q + CW'(1);
				HEAD_W: col_q <= (col_q == '0) ? LAST : col_q - CW'(1);
				default: col_q <= col_q;
			endcase
		end
	end

	assign col   = col_q;
	assign row   = row_q;
	assign head  = head_q;
	assign count = count_q;

endmodule

### hdl/lant_ctrl.sv
// ----------------------------------------------------------------------------
// lant_ctrl
// Item sequencer: clearing pass, configuration registers, the read-modify-write
// sequences for ant steps and brush painting, and cell reads.
// ----------------------------------------------------------------------------
module lant_ctrl import lant_pkg::*; #(
	parameter int GRID_SIDE = LANT_GRID_SIDE_DEF,
	localparam int CW = $clog2(GRID_SIDE),
	localparam int PW = ((CW > FIELD_W) ? CW : FIELD_W) + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [FIELD_W-1:0]   pos_x,
	input  logic [FIELD_W-1:0]   pos_y,
	// configuration
	input  logic                 wr_en,
	input  logic                 wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	// result
	output logic                 done,
	output logic                 cell_value,
	// ant
	input  logic [CW-1:0]        ant_col,
	input  logic [CW-1:0]        ant_row,
	output logic                 step_en,
	output logic                 step_cell,
	// grid memory
	output logic                 mem_rd_en,
	output logic [CW-1:0]        mem_rd_addr,
	input  logic [GRID_SIDE-1:0] mem_rd_data,
	output logic                 mem_wr_en,
	output logic [CW-1:0]        mem_wr_addr,
	output logic [GRID_SIDE-1:0] mem_wr_data
);

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_STEP_RD  = 8'b0000_0100,
		ST_STEP_WR  = 8'b0000_1000,
		ST_PAINT_RD = 8'b0001_0000,
		ST_PAINT_WR = 8'b0010_0000,
		ST_PEEK_RD  = 8'b0100_0000,
		ST_PEEK_WR  = 8'b1000_0000
	} state_t;

	localparam logic [CW-1:0]        LAST_ROW = CW'(GRID_SIDE - 1);
	localparam logic [PW-1:0]        SIDE_W   = PW'(GRID_SIDE);
	localparam logic [GRID_SIDE-1:0] ONE_BIT  = GRID_SIDE'(1);

	state_t               state_q;
	logic [CW-1:0]        clr_q;
	logic [15:0]          steps_q;
	logic [8:0]           reach_q;
	logic [15:0]          left_q;
	logic [FIELD_W-1:0]   x_q;
	logic [FIELD_W-1:0]   y_q;
	logic                 paint_v_q;
	logic [GRID_SIDE-1:0] mask_q;
	logic                 centre_q;
	logic                 up_q;
	logic [8:0]           arm_q;
	logic [8:0]           lim_q;
	logic                 done_q;
	logic                 cell_q;

	logic [PW-1:0]        in_xw;
	logic [PW-1:0]        in_yw;
	logic                 in_grid;
	logic [8:0]           lim_in;
	logic [GRID_SIDE-1:0] hmask;
	logic [PW-1:0]        xw;
	logic [PW-1:0]        yw;
	logic [PW-1:0]        aw;
	logic [PW-1:0]        dn_sum;
	logic [PW-1:0]        tgt_w;
	logic                 tgt_ok;
	logic [CW-1:0]        tgt_row;
	logic [CW-1:0]        x_col;
	logic [GRID_SIDE-1:0] paint_row;

	// accepted item checks and brush reach
	assign in_xw   = PW'(pos_x);
	assign in_yw   = PW'(pos_y);
	assign in_grid = (in_xw < SIDE_W) && (in_yw < SIDE_W);
	assign lim_in  = (reach_q == 9'd0) ? 9'd0 : reach_q - 9'd1;

	// horizontal arm mask, each column checked on its own
	always_comb begin
		logic [PW-1:0] cw;
		logic [PW-1:0] span;
		for (int c = 0; c < GRID_SIDE; c++) begin
			cw       = PW'(c);
			span     = (cw <= in_xw) ? in_xw - cw : cw - in_xw;
			hmask[c] = span <= PW'(lim_in);
		end
	end

	// row targeted by the brush sequence, clipped at the grid edges
	assign xw      = PW'(x_q);
	assign yw      = PW'(y_q);
	assign aw      = PW'(arm_q);
	assign dn_sum  = yw + aw;
	assign tgt_w   = centre_q ? yw : (up_q ? yw - aw : dn_sum);
	assign tgt_ok  = centre_q || (up_q ? (aw <= yw) : (dn_sum < SIDE_W));
	assign tgt_row = tgt_w[CW-1:0];
	assign x_col   = xw[CW-1:0];

	assign paint_row = paint_v_q ? (mem_rd_data | mask_q) : (mem_rd_data & ~mask_q);

	// ant step uses the cell under the ant
	assign step_cell = mem_rd_data[ant_col];
	assign step_en   = (state_q == ST_STEP_WR);

	// memory port control
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = ant_row;
		mem_wr_en   = 1'b0;
		mem_wr_addr = ant_row;
		mem_wr_data = mem_rd_data ^ (ONE_BIT << ant_col);
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = clr_q;
				mem_wr_data = '0;
			end
			ST_STEP_RD: begin
				mem_rd_en = 1'b1;
			end
			ST_STEP_WR: begin
				mem_wr_en = 1'b1;
			end
			ST_PAINT_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = tgt_row;
			end
			ST_PAINT_WR: begin
				mem_wr_en   = tgt_ok;
				mem_wr_addr = tgt_row;
				mem_wr_data = paint_row;
			end
			ST_PEEK_RD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = yw[CW-1:0];
			end
			default: begin
				mem_rd_en = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RST;
			reach_q <= REACH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_STEPS: steps_q <= wr_data;
				REG_REACH: reach_q <= wr_data[8:0];
				default:   steps_q <= steps_q;
			endcase
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			x_q       <= pos_x;
			y_q       <= pos_y;
			paint_v_q <= (func == FUNC_PAINT_B);
			mask_q    <= hmask;
			lim_q     <= lim_in;
		end else if (state_q == ST_PAINT_WR && centre_q) begin
			mask_q <= ONE_BIT << x_col;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			left_q   <= 16'd0;
			centre_q <= 1'b0;
			up_q     <= 1'b0;
			arm_q    <= 9'd0;
			done_q   <= 1'b0;
			cell_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				// zero one row per cycle after reset
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				// command transfer
				ST_IDLE: begin
					if (start) begin
						cell_q <= 1'b0;
						case (func)
							FUNC_RUN: begin
								if (steps_q == 16'd0) begin
									done_q <= 1'b1;
								end else begin
									left_q  <= steps_q;
									state_q <= ST_STEP_RD;
								end
							end
							FUNC_PAINT_B, FUNC_PAINT_W: begin
								if (in_grid) begin
									centre_q <= 1'b1;
									up_q     <= 1'b1;
									arm_q    <= 9'd1;
									state_q  <= ST_PAINT_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							FUNC_READ: begin
								if (in_grid) begin
									state_q <= ST_PEEK_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_STEP_RD: begin
					state_q <= ST_STEP_WR;
				end
				// flip the cell and move the ant
				ST_STEP_WR: begin
					left_q <= left_q - 16'd1;
					if (left_q == 16'd1) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_STEP_RD;
					end
				end
				ST_PAINT_RD: begin
					state_q <= ST_PAINT_WR;
				end
				// centre row first, then up and down rows for each arm offset
				ST_PAINT_WR: begin
					if (centre_q) begin
						centre_q <= 1'b0;
						if (lim_q == 9'd0) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PAINT_RD;
						end
					end else if (up_q) begin
						up_q    <= 1'b0;
						state_q <= ST_PAINT_RD;
					end else if (arm_q == lim_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						arm_q   <= arm_q + 9'd1;
						up_q    <= 1'b1;
						state_q <= ST_PAINT_RD;
					end
				end
				ST_PEEK_RD: begin
					state_q <= ST_PEEK_WR;
				end
				ST_PEEK_WR: begin
					cell_q  <= mem_rd_data[x_col];
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cell_value = cell_q;

`ifndef SYNTHESIS
	// a step is never taken with no steps left
	a_step_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP_WR) |-> (left_q != 16'd0))
		else $error("ant step with zero steps left");

	// every brush write follows its row read
	a_paint_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAINT_WR) |-> ($past(state_q) == ST_PAINT_RD))
		else $error("brush write without preceding row read");

	// modifying writes use data read in the cycle before
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && state_q != ST_CLEAR) |-> $past(mem_rd_en))
		else $error("grid write without preceding read");

	// a result only shows once the block is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");
`endif

endmodule

### hdl/langton_ant_grid_stepper_unit.sv
// ----------------------------------------------------------------------------
// langton_ant_grid_stepper_unit
// Langton's ant on a square torus bit grid with brush painting and cell reads.
//
//   channel   signals                                       direction
//   command   start, busy, func, pos_x, pos_y               in (busy out)
//   result    done, ant_x, ant_y, heading, step_total,
//             cell_value                                    out
//   config    wr_en, wr_index, wr_data                      in
//
// A command transfers when start is high and busy is low; done strobes for one
// cycle with the result. The grid memory holds one row per word. Each ant step
// and each painted row is a read-modify-write of one row, and a cell read reads
// its row; items that do no work strobe done without leaving idle. After reset
// a clearing pass zeroes one row per cycle with busy high. The result cannot be
// stalled.
// ----------------------------------------------------------------------------
module langton_ant_grid_stepper_unit import lant_pkg::*; #(
	parameter int GRID_SIDE = LANT_GRID_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [FIELD_W-1:0] pos_x,
	input  logic [FIELD_W-1:0] pos_y,
	// configuration
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [CFG_W-1:0]   wr_data,
	// result
	output logic               done,
	output logic [FIELD_W-1:0] ant_x,
	output logic [FIELD_W-1:0] ant_y,
	output logic [1:0]         heading,
	output logic [31:0]        step_total,
	output logic               cell_value
);

	localparam int CW = $clog2(GRID_SIDE);
	localparam int PW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

	logic [CW-1:0]        ant_col;
	logic [CW-1:0]        ant_row;
	logic                 step_en;
	logic                 step_cell;
	logic                 mem_rd_en;
	logic [CW-1:0]        mem_rd_addr;
	logic [GRID_SIDE-1:0] mem_rd_data;
	logic                 mem_wr_en;
	logic [CW-1:0]        mem_wr_addr;
	logic [GRID_SIDE-1:0] mem_wr_data;
	logic [PW-1:0]        col_w;
	logic [PW-1:0]        row_w;

	// sequencer
	lant_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.done        (done),
		.cell_value  (cell_value),
		.ant_col     (ant_col),
		.ant_row     (ant_row),
		.step_en     (step_en),
		.step_cell   (step_cell),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	// ant state
	lant_ant #(.GRID_SIDE(GRID_SIDE)) u_ant (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.step_cell (step_cell),
		.col       (ant_col),
		.row       (ant_row),
		.head      (heading),
		.count     (step_total)
	);

	// cell grid
	lant_grid_mem #(.GRID_SIDE(GRID_SIDE)) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// position fields at port width
	assign col_w = PW'(ant_col);
	assign row_w = PW'(ant_row);
	assign ant_x = col_w[FIELD_W-1:0];
	assign ant_y = row_w[FIELD_W-1:0];

endmodule
